>>> hw/rtl/max_intensity_projection_z_defines.svh
// Assertion macros used by the checker file of the projection block.
`ifndef MAX_INTENSITY_PROJECTION_Z_DEFINES_SVH
`define MAX_INTENSITY_PROJECTION_Z_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define MIPZ_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define MIPZ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/mipz_pkg.sv
// Types and constants shared by the projection block modules.
package mipz_pkg;

    localparam int MAX_PIXELS     = 65536;
    localparam int MAX_COMPONENTS = 3;
    localparam int STORE_DEPTH    = MAX_PIXELS * MAX_COMPONENTS;
    localparam int PIX_W          = $clog2(MAX_PIXELS);
    localparam int ADDR_W         = $clog2(STORE_DEPTH);

    localparam int SAMPLE_W = 8;
    localparam int COMP_W   = 2;
    localparam int COLS_W   = 11;
    localparam int ROWS_W   = 11;
    localparam int SLICES_W = 13;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 10;
    localparam int SLICE_W  = 12;
    localparam int CFG_W    = 13;

    localparam logic [COLS_W-1:0]   COLS_LIMIT   = 11'd1024;
    localparam logic [ROWS_W-1:0]   ROWS_LIMIT   = 11'd1024;
    localparam logic [SLICES_W-1:0] SLICES_LIMIT = 13'd4096;
    localparam logic [COMP_W-1:0]   COMPS_LIMIT  = COMP_W'(MAX_COMPONENTS);

    // Output queue sizing
    localparam int FIFO_DEPTH = 8;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = FPTR_W + 1;

    typedef enum logic [1:0] {
        CFG_COLUMNS    = 2'd0,
        CFG_ROWS       = 2'd1,
        CFG_SLICES     = 2'd2,
        CFG_COMPONENTS = 2'd3
    } mipz_cfg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [COMP_W-1:0]   comp;
        logic                first;
        logic                last;
        logic                done;
    } mipz_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [COMP_W-1:0]   comp;
        logic                done;
    } mipz_result_t;

endpackage

>>> hw/rtl/mipz_ctrl.sv
// Configuration registers and raster counters; tags each accepted sample.
module mipz_ctrl import mipz_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                accept,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                item_valid,
    output mipz_item_t          item,
    output logic [COLS_W-1:0]   cols
);

    logic [COLS_W-1:0]   cols_cfg_reg;
    logic [ROWS_W-1:0]   rows_cfg_reg;
    logic [SLICES_W-1:0] slices_cfg_reg;
    logic [COMP_W-1:0]   comps_cfg_reg;

    logic [COL_W-1:0]   col_reg,   col_next;
    logic [ROW_W-1:0]   row_reg,   row_next;
    logic [SLICE_W-1:0] slice_reg, slice_next;
    logic [COMP_W-1:0]  comp_reg,  comp_next;

    logic               item_valid_reg;
    mipz_item_t         item_reg, item_next;

    logic [COLS_W-1:0]   cols_c;
    logic [ROWS_W-1:0]   rows_c;
    logic [SLICES_W-1:0] slices_c;
    logic [COMP_W-1:0]   comps_c;
    logic                comp_wrap, col_wrap, row_wrap, slice_wrap;
    logic [COMP_W-1:0]   comp_eff;

    assign cfg_ready = 1'b1;

    // Zero counts as one, oversize saturates
    always_comb begin
        cols_c   = (cols_cfg_reg == '0) ? COLS_W'(1) :
                   (cols_cfg_reg > COLS_LIMIT) ? COLS_LIMIT : cols_cfg_reg;
        rows_c   = (rows_cfg_reg == '0) ? ROWS_W'(1) :
                   (rows_cfg_reg > ROWS_LIMIT) ? ROWS_LIMIT : rows_cfg_reg;
        slices_c = (slices_cfg_reg == '0) ? SLICES_W'(1) :
                   (slices_cfg_reg > SLICES_LIMIT) ? SLICES_LIMIT : slices_cfg_reg;
        comps_c  = (comps_cfg_reg == '0) ? COMP_W'(1) :
                   (comps_cfg_reg > COMPS_LIMIT) ? COMPS_LIMIT : comps_cfg_reg;
    end

    always_comb begin
        comp_wrap  = ({1'b0, comp_reg} + 3'd1) >= {1'b0, comps_c};
        col_wrap   = ({1'b0, col_reg} + COLS_W'(1)) >= cols_c;
        row_wrap   = ({1'b0, row_reg} + ROWS_W'(1)) >= rows_c;
        slice_wrap = ({1'b0, slice_reg} + SLICES_W'(1)) >= slices_c;
        comp_eff   = (comp_reg >= comps_c) ? comps_c - COMP_W'(1) : comp_reg;

        comp_next  = comp_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        slice_next = slice_reg;
        // Nested advance: each counter moves only when the inner one wraps
        if (comp_wrap) begin
            comp_next = '0;
            if (col_wrap) begin
                col_next = '0;
                if (row_wrap) begin
                    row_next = '0;
                    slice_next = slice_wrap ? '0 : slice_reg + SLICE_W'(1);
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end else begin
            comp_next = comp_reg + COMP_W'(1);
        end

        item_next.sample = sample;
        item_next.row    = row_reg;
        item_next.col    = col_reg;
        item_next.comp   = comp_eff;
        item_next.first  = (slice_reg == '0);
        item_next.last   = slice_wrap;
        item_next.done   = comp_wrap && col_wrap && row_wrap && slice_wrap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg   <= COLS_W'(1);
            rows_cfg_reg   <= ROWS_W'(1);
            slices_cfg_reg <= SLICES_W'(1);
            comps_cfg_reg  <= COMP_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (mipz_cfg_idx_t'(cfg_index))
                CFG_COLUMNS:    cols_cfg_reg   <= cfg_data[COLS_W-1:0];
                CFG_ROWS:       rows_cfg_reg   <= cfg_data[ROWS_W-1:0];
                CFG_SLICES:     slices_cfg_reg <= cfg_data[SLICES_W-1:0];
                CFG_COMPONENTS: comps_cfg_reg  <= cfg_data[COMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            slice_reg      <= '0;
            comp_reg       <= '0;
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= accept;
            if (accept) begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                slice_reg <= slice_next;
                comp_reg  <= comp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;
    assign cols       = cols_c;

endmodule

>>> hw/rtl/mipz_store.sv
// Pixel address pipeline and projection store read-modify-write.
module mipz_store import mipz_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  mipz_item_t        item,
    input  logic [COLS_W-1:0] cols,
    output logic              s2_busy,
    output logic              s3_busy,
    output logic              res_valid,
    output mipz_result_t      res
);

    localparam int PROD_W = ROW_W + COLS_W;

    logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH];

    logic               s2_valid_reg;
    mipz_item_t         s2_item_reg;
    logic [PIX_W-1:0]   s2_pix_reg;

    logic               s3_valid_reg;
    mipz_item_t         s3_item_reg;
    logic [ADDR_W-1:0]  s3_addr_reg;
    logic [SAMPLE_W-1:0] rdata_reg;

    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    logic [SAMPLE_W-1:0] fwd_data_reg;

    logic [PROD_W-1:0]   pix_full;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] old_value;
    logic [SAMPLE_W-1:0] kept;

    // Pixel index wraps modulo MAX_PIXELS by keeping the low bits
    assign pix_full = PROD_W'(item.row) * PROD_W'(cols) + PROD_W'(item.col);

    // Times three as shift-add, then the component
    assign rd_addr = {s2_pix_reg, 1'b0} + ADDR_W'(s2_pix_reg) + ADDR_W'(s2_item_reg.comp);

    // Forward the write of the previous cycle; the read saw the old byte
    assign old_value = (fwd_valid_reg && fwd_addr_reg == s3_addr_reg) ? fwd_data_reg
                                                                       : rdata_reg;
    assign kept = (s3_item_reg.first || s3_item_reg.sample > old_value) ?
                  s3_item_reg.sample : old_value;

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            rdata_reg <= store_mem[rd_addr];
        end
        if (s3_valid_reg) begin
            store_mem[s3_addr_reg] <= kept;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg  <= item_valid;
            s3_valid_reg  <= s2_valid_reg;
            fwd_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_item_reg  <= item;
        s2_pix_reg   <= pix_full[PIX_W-1:0];
        s3_item_reg  <= s2_item_reg;
        s3_addr_reg  <= rd_addr;
        fwd_addr_reg <= s3_addr_reg;
        fwd_data_reg <= kept;
    end

    assign s2_busy    = s2_valid_reg;
    assign s3_busy    = s3_valid_reg;
    assign res_valid  = s3_valid_reg && s3_item_reg.last;
    assign res.value  = kept;
    assign res.comp   = s3_item_reg.comp;
    assign res.done   = s3_item_reg.done;

endmodule

>>> hw/rtl/mipz_fifo.sv
// Output queue that decouples the store pipeline from the result consumer.
module mipz_fifo import mipz_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mipz_result_t      push_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mipz_result_t      out_data,
    output logic [FCNT_W-1:0] count
);

    mipz_result_t      entry_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] head_reg, head_next;
    logic [FPTR_W-1:0] tail_reg, tail_next;
    logic [FCNT_W-1:0] count_reg, count_next;
    logic              pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_mem[head_reg];
    assign count     = count_reg;

    always_comb begin
        head_next  = pop  ? head_reg + FPTR_W'(1) : head_reg;
        tail_next  = push ? tail_reg + FPTR_W'(1) : tail_reg;
        count_next = count_reg + FCNT_W'(push) - FCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_mem[tail_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> hw/rtl/max_intensity_projection_z.sv
// Maximum intensity projection along depth of an 8-bit volume stream.
// Samples enter in raster order (component, column, row, slice) at a sustained
// rate of one per clock while s_tready stays high. The projection store has
// one read and one write port: it is read in one stage and written in the next,
// with the previous write forwarded so that consecutive samples hitting the
// same entry still go back to back. Results pass the pipeline stages and the
// output queue to the m_ side only during the last slice, with m_tlast on the
// final byte of the projection. Results wait in an 8-entry queue; s_tready
// drops only when that queue plus the three pipeline stages would overflow.
// The store needs no clearing pass: the first slice overwrites every entry.
// Configuration writes are taken every cycle and are meant for idle periods.
module max_intensity_projection_z import mipz_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // Config write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    // Sample input
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] sample_value
    // Projected output
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,    // [7:0] projected_value
    output logic [1:0]          m_tuser,    // [1:0] component_index
    output logic                m_tlast     // image_done
);

    logic              accept;
    logic              s1_busy, s2_busy, s3_busy;
    mipz_item_t        item;
    logic [COLS_W-1:0] cols;
    logic              res_valid;
    mipz_result_t      res;
    mipz_result_t      out_res;
    logic [FCNT_W-1:0] fifo_count;
    logic [FCNT_W:0]   occupancy;

    // Reserve queue room for every request still in the pipeline
    assign occupancy = {1'b0, fifo_count} + (FCNT_W+1)'(s1_busy)
                     + (FCNT_W+1)'(s2_busy) + (FCNT_W+1)'(s3_busy);
    assign s_tready  = occupancy < (FCNT_W+1)'(FIFO_DEPTH);
    assign accept    = s_tvalid && s_tready;

    mipz_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .sample     (s_tdata),
        .item_valid (s1_busy),
        .item       (item),
        .cols       (cols)
    );

    mipz_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s1_busy),
        .item       (item),
        .cols       (cols),
        .s2_busy    (s2_busy),
        .s3_busy    (s3_busy),
        .res_valid  (res_valid),
        .res        (res)
    );

    mipz_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res),
        .count     (fifo_count)
    );

    assign m_tdata = out_res.value;
    assign m_tuser = out_res.comp;
    assign m_tlast = out_res.done;

endmodule

>>> hw/rtl/mipz_checker.sv
// Port-level checks for the projection block, bound to its top level.
`include "max_intensity_projection_z_defines.svh"

module mipz_checker import mipz_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    logic        out_stalled;
    logic [10:0] out_bits;

    assign out_stalled = m_tvalid && !m_tready;
    assign out_bits    = {m_tlast, m_tuser, m_tdata};

    `MIPZ_ASSERT_RST(a_out_hold, aclk, aresetn, out_stalled |=> m_tvalid, "result dropped")
    `MIPZ_ASSERT_RST(a_out_stable, aclk, aresetn, out_stalled |=> $stable(out_bits), "result changed")
    `MIPZ_ASSERT_RST(a_comp_range, aclk, aresetn, m_tvalid |-> m_tuser != 2'd3, "bad component")
    `MIPZ_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid, "result after reset")

endmodule

bind max_intensity_projection_z mipz_checker u_mipz_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the depth-wise maximum intensity projection block.
module testbench;
    import mipz_pkg::*;

    localparam logic [3:0] MASK_COLUMNS    = 4'(1 << CFG_COLUMNS);
    localparam logic [3:0] MASK_ROWS       = 4'(1 << CFG_ROWS);
    localparam logic [3:0] MASK_SLICES     = 4'(1 << CFG_SLICES);
    localparam logic [3:0] MASK_COMPONENTS = 4'(1 << CFG_COMPONENTS);
    localparam logic [3:0] MASK_ALL        = '1;
    localparam int         SETTLE_CYCLES   = 8;
    localparam int         RANDOM_SAMPLES  = 250;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    mipz_cfg_idx_t       cfg_index = CFG_COLUMNS;
    logic [CFG_W-1:0]    cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [7:0]          m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;

    // Projection predictor state
    logic [SAMPLE_W-1:0] proj_store [0:STORE_DEPTH-1];
    int unsigned         comp_pos, col_pos, row_pos, slice_pos;
    logic [COLS_W-1:0]   cols_reg   = 1;
    logic [ROWS_W-1:0]   rows_reg   = 1;
    logic [SLICES_W-1:0] slices_reg = 1;
    logic [COMP_W-1:0]   comps_reg  = 1;
    mipz_result_t        projected_q [$];

    int unsigned         mismatches  = 0;
    int unsigned         total_sent  = 0;
    bit                  idle_on     = 1'b1;
    int unsigned         stall_left  = 0;
    int unsigned         calm_left   = 0;
    int unsigned         calm_sends  = 0;

    always #1 aclk = ~aclk;

    max_intensity_projection_z dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    function automatic int unsigned clamp_count(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void project_sample(input logic [SAMPLE_W-1:0] sample);
        int unsigned cols, rows, slices, comps, comp, pixel, addr;
        bit is_first, on_last, done;
        logic [SAMPLE_W-1:0] kept;
        mipz_result_t res;
        cols   = clamp_count(cols_reg, COLS_LIMIT);
        rows   = clamp_count(rows_reg, ROWS_LIMIT);
        slices = clamp_count(slices_reg, SLICES_LIMIT);
        comps  = clamp_count(comps_reg, MAX_COMPONENTS);
        comp   = (comp_pos >= comps) ? comps - 1 : comp_pos;
        pixel  = (row_pos * cols + col_pos) % MAX_PIXELS;
        addr   = pixel * MAX_COMPONENTS + comp;
        is_first = (slice_pos == 0);
        on_last  = (slice_pos + 1 >= slices);
        if (is_first) kept = sample;
        else kept = (sample > proj_store[addr]) ? sample : proj_store[addr];
        proj_store[addr] = kept;

        // Ripple the raster position: component, column, row, slice
        done = 1'b0;
        if (comp_pos + 1 >= comps) begin
            comp_pos = 0;
            if (col_pos + 1 >= cols) begin
                col_pos = 0;
                if (row_pos + 1 >= rows) begin
                    row_pos = 0;
                    if (slice_pos + 1 >= slices) begin
                        slice_pos = 0;
                        done = 1'b1;
                    end else begin
                        slice_pos++;
                    end
                end else begin
                    row_pos++;
                end
            end else begin
                col_pos++;
            end
        end else begin
            comp_pos++;
        end

        if (on_last) begin
            res.value = kept;
            res.comp  = comp[COMP_W-1:0];
            res.done  = done;
            projected_q.push_back(res);
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg(input mipz_cfg_idx_t idx);
        logic [CFG_W-1:0] v;
        if ($urandom_range(0, 7) == 0) begin
            v = '0;
        end else begin
            case (idx)
                CFG_COLUMNS: v = CFG_W'($urandom_range(1, 6));
                CFG_ROWS:    v = CFG_W'($urandom_range(1, 4));
                CFG_SLICES:  v = CFG_W'($urandom_range(1, 5));
                default:     v = CFG_W'($urandom_range(1, 3));
            endcase
        end
        // Junk above the register width must be dropped by the block
        case (idx)
            CFG_COLUMNS, CFG_ROWS: v[CFG_W-1:COLS_W] = 2'($urandom);
            CFG_COMPONENTS:        v[CFG_W-1:COMP_W] = 11'($urandom);
            default: ;
        endcase
        return v;
    endfunction

    task automatic set_regs(input logic [3:0] mask, input logic [CFG_W-1:0] cols,
                            input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] slices,
                            input logic [CFG_W-1:0] comps);
        logic [CFG_W-1:0] vals [4];
        vals[CFG_COLUMNS]    = cols;
        vals[CFG_ROWS]       = rows;
        vals[CFG_SLICES]     = slices;
        vals[CFG_COMPONENTS] = comps;
        for (int i = 0; i < 4; i++) begin
            if (mask[i]) begin
                cfg_valid <= 1'b1;
                cfg_index <= mipz_cfg_idx_t'(i);
                cfg_data  <= vals[i];
                @(posedge aclk);
                while (!cfg_ready) @(posedge aclk);
                case (mipz_cfg_idx_t'(i))
                    CFG_COLUMNS: cols_reg   = vals[i][COLS_W-1:0];
                    CFG_ROWS:    rows_reg   = vals[i][ROWS_W-1:0];
                    CFG_SLICES:  slices_reg = vals[i][SLICES_W-1:0];
                    default:     comps_reg  = vals[i][COMP_W-1:0];
                endcase
            end
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int unsigned pick;
        if (calm_sends > 0) begin
            calm_sends--;
        end else if (idle_on) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else if (pick == 2) begin
                calm_sends = $urandom_range(20, 60);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        total_sent++;
        project_sample(value);
    endtask

    // Stream samples until the raster position is back at the start of a volume
    task automatic run_projection();
        do begin
            send_sample(random_sample());
        end while (comp_pos != 0 || col_pos != 0 || row_pos != 0 || slice_pos != 0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (projected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_default_config();
        send_sample(8'h00);
        send_sample(8'hFF);
        send_sample(8'hA5);
        drain();
    endtask

    task automatic test_zero_registers();
        set_regs(MASK_ALL, 13'h1800, 13'h1800, 13'h0000, 13'h1FFC);
        send_sample(8'h5A);
        send_sample(8'h00);
        drain();
    endtask

    task automatic test_small_volume();
        // Second volume is lower everywhere: stale maxima must not leak through
        logic [SAMPLE_W-1:0] seq [24] = '{
            8'd10, 8'd200, 8'd0,   8'd255,
            8'd5,  8'd201, 8'd1,   8'd0,
            8'd7,  8'd100, 8'd255, 8'd3,
            8'd1,  8'd1,   8'd1,   8'd1,
            8'd0,  8'd0,   8'd0,   8'd0,
            8'd2,  8'd0,   8'd0,   8'd0
        };
        set_regs(MASK_ALL, 2, 1, 3, 2);
        foreach (seq[i]) send_sample(seq[i]);
        drain();
    endtask

    task automatic test_midrun_config();
        set_regs(MASK_ALL, 5, 3, 1, 3);
        repeat (7) send_sample(random_sample());
        drain();
        // Both counters sit at or past their new bounds
        set_regs(MASK_COLUMNS | MASK_COMPONENTS, 2, 0, 0, 1);
        run_projection();
        drain();

        set_regs(MASK_ALL, 2, 2, 4, 2);
        repeat (21) send_sample(random_sample());
        drain();
        set_regs(MASK_SLICES, 0, 0, 2, 0);
        run_projection();
        drain();

        set_regs(MASK_SLICES, 0, 0, 3, 0);
        repeat (19) send_sample(random_sample());
        drain();
        set_regs(MASK_SLICES, 0, 0, 5, 0);
        run_projection();
        drain();

        set_regs(MASK_SLICES, 0, 0, 4, 0);
        repeat (26) send_sample(random_sample());
        drain();
        set_regs(MASK_SLICES, 0, 0, 2, 0);
        run_projection();
        drain();
    endtask

    task automatic test_random_volumes();
        int unsigned start;
        start = total_sent;
        while (total_sent - start < RANDOM_SAMPLES) begin
            if ($urandom_range(0, 3) != 0) begin
                drain();
                set_regs(4'($urandom), pick_reg(CFG_COLUMNS), pick_reg(CFG_ROWS),
                         pick_reg(CFG_SLICES), pick_reg(CFG_COMPONENTS));
            end
            run_projection();
        end
        drain();
    endtask

    task automatic test_extreme_sizes();
        idle_on = 1'b0;
        // Oversized column count saturates at 1024
        set_regs(MASK_ALL, 13'h07FF, 1, 1, 1);
        run_projection();
        drain();
    endtask

    always @(posedge aclk) begin : sink_stall
        if (!idle_on) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (calm_left > 0) begin
            calm_left--;
            m_tready <= 1'b1;
        end else begin
            case ($urandom_range(0, 9))
                0: begin
                    stall_left = $urandom_range(0, 9);
                    m_tready <= 1'b0;
                end
                1: begin
                    calm_left = $urandom_range(20, 60);
                    m_tready <= 1'b1;
                end
                default: m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin : check_results
        mipz_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (projected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, got value %0d comp %0d last %0b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatches++;
            end else begin
                want = projected_q.pop_front();
                if (m_tdata !== want.value) begin
                    $display("%0t: projected_value expected %0d, got %0d",
                             $time, want.value, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== want.comp) begin
                    $display("%0t: component_index expected %0d, got %0d",
                             $time, want.comp, m_tuser);
                    mismatches++;
                end
                if (m_tlast !== want.done) begin
                    $display("%0t: image_done expected %0b, got %0b",
                             $time, want.done, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("[max_intensity_projection_z] ERROR");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_config();
        test_zero_registers();
        test_small_volume();
        test_midrun_config();
        test_random_volumes();
        test_extreme_sizes();
        if (mismatches == 0) begin
            $display("[max_intensity_projection_z] OK");
        end else begin
            $display("[max_intensity_projection_z] ERROR");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/mipz_pkg.sv
hw/rtl/mipz_ctrl.sv
hw/rtl/mipz_store.sv
hw/rtl/mipz_fifo.sv
hw/rtl/max_intensity_projection_z.sv
hw/rtl/mipz_checker.sv
tb/testbench.sv
